>>> hdl/htfd_pkg.sv
// Package with shared types, constants and the CRC-8 step for the frame decoder.
package htfd_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [12:0] TEMP_SCALE  = 13'd4375;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [9:0]  HUM_SCALE   = 10'd625;

    // byte positions within a frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       frame_start;
    } t_item;

    // one byte through the CRC-8 register, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/htfd_in_reg.sv
// Input register stage holding one received byte and its start flag.
module htfd_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_frame_start,
    input  logic                 i_take,
    output logic                 o_ready,
    output htfd_pkg::t_item      o_item
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_start;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte  <= i_data_byte;
            r_start <= i_frame_start;
        end
    end

    assign o_item.valid       = r_valid;
    assign o_item.data_byte   = r_byte;
    assign o_item.frame_start = r_start;

endmodule

>>> hdl/htfd_core.sv
// Frame state, CRC check, unit conversion and result register.
module htfd_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  htfd_pkg::t_item      i_item,
    output logic                 o_take,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [14:0]          o_temperature_centi,
    output logic [13:0]          o_humidity_centi,
    output logic                 o_crc_error
);

    logic [2:0]  r_pos;
    logic [7:0]  r_crc;
    logic [7:0]  r_temp_hi;
    logic [7:0]  r_hum_hi;
    logic [14:0] r_temp_c;
    logic [13:0] r_hum_c;
    logic        r_bad;
    logic        r_out_valid;
    logic [14:0] r_out_temp;
    logic [13:0] r_out_hum;
    logic        r_out_err;

    logic [2:0]  n_pos;
    logic [7:0]  n_crc;
    logic        n_bad;
    logic [2:0]  pos;
    logic        is_last;
    logic        out_free;
    logic [7:0]  crc_step;
    logic        crc_miss;
    logic [28:0] temp_prod;
    logic [25:0] hum_prod;

    assign pos      = i_item.frame_start ? htfd_pkg::POS_T_HI : r_pos;
    assign is_last  = (pos == htfd_pkg::POS_H_CRC);
    assign out_free = !r_out_valid || i_out_ready;
    assign o_take   = i_item.valid && (!is_last || out_free);

    assign crc_step  = htfd_pkg::crc8_byte(
        (pos == htfd_pkg::POS_T_HI || pos == htfd_pkg::POS_H_HI) ? htfd_pkg::CRC_INIT : r_crc,
        i_item.data_byte);
    assign crc_miss  = (i_item.data_byte != r_crc);
    assign temp_prod = 29'(htfd_pkg::TEMP_SCALE) * 29'({r_temp_hi, i_item.data_byte});
    assign hum_prod  = 26'(htfd_pkg::HUM_SCALE) * 26'({r_hum_hi, i_item.data_byte});

    always_comb begin
        n_pos = htfd_pkg::POS_T_HI;
        n_crc = r_crc;
        n_bad = r_bad;
        unique case (pos)
            htfd_pkg::POS_T_HI: begin
                n_pos = htfd_pkg::POS_T_LO;
                n_crc = crc_step;
                n_bad = 1'b0;
            end
            htfd_pkg::POS_T_LO: begin
                n_pos = htfd_pkg::POS_T_CRC;
                n_crc = crc_step;
            end
            htfd_pkg::POS_T_CRC: begin
                n_pos = htfd_pkg::POS_H_HI;
                n_crc = htfd_pkg::CRC_INIT;
                n_bad = crc_miss;
            end
            htfd_pkg::POS_H_HI: begin
                n_pos = htfd_pkg::POS_H_LO;
                n_crc = crc_step;
            end
            htfd_pkg::POS_H_LO: begin
                n_pos = htfd_pkg::POS_H_CRC;
                n_crc = crc_step;
            end
            default: begin
                n_pos = htfd_pkg::POS_T_HI;
                n_crc = htfd_pkg::CRC_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= htfd_pkg::POS_T_HI;
            r_crc <= htfd_pkg::CRC_INIT;
            r_bad <= 1'b0;
        end else if (o_take) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            r_bad <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            if (pos == htfd_pkg::POS_T_HI) begin
                r_temp_hi <= i_item.data_byte;
            end
            if (pos == htfd_pkg::POS_T_LO) begin
                r_temp_c <= 15'(temp_prod >> 14) - htfd_pkg::TEMP_OFFSET;
            end
            if (pos == htfd_pkg::POS_H_HI) begin
                r_hum_hi <= i_item.data_byte;
            end
            if (pos == htfd_pkg::POS_H_LO) begin
                r_hum_c <= 14'(hum_prod >> 12);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_take && is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && is_last) begin
            r_out_temp <= r_temp_c;
            r_out_hum  <= r_hum_c;
            r_out_err  <= r_bad || crc_miss;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_temperature_centi = r_out_temp;
    assign o_humidity_centi    = r_out_hum;
    assign o_crc_error         = r_out_err;

endmodule

>>> hdl/humidity_temp_frame_decoder.sv
// Top level of the humidity/temperature measurement frame decoder.
//
// The slave stream carries one frame byte per transfer: temperature high,
// low and CRC bytes, then humidity high, low and CRC bytes. tuser marks the
// first byte of a frame and restarts the byte position; without it the
// position wraps after every sixth byte.
// After the sixth byte one result leaves on the master stream: temperature in
// hundredths of a degree C and humidity in hundredths of a percent in tdata,
// and a CRC error flag in tuser that is set if either word failed CRC-8.
// Timing: a byte is registered on transfer and reaches the core in the next cycle;
// the result of the last byte is registered in the result register for the master side.
// Throughput: one byte per cycle unless a sixth byte stalls; the CRC step and
// each conversion multiply sit between the input register and the result register.
// While a result waits, bytes that produce no result keep flowing; a sixth
// byte waits in the input register until the result register frees up.
// Reset clears the byte position, the CRC and both valid flags.
module humidity_temp_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
    output logic        m_axis_tuser    // [0] crc_error
);

    htfd_pkg::t_item item;
    logic            take;
    logic [14:0]     temp_c;
    logic [13:0]     hum_c;

    htfd_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .i_data_byte   (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_take        (take),
        .o_ready       (s_axis_tready),
        .o_item        (item)
    );

    htfd_core u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_item              (item),
        .o_take              (take),
        .i_out_ready         (m_axis_tready),
        .o_out_valid         (m_axis_tvalid),
        .o_temperature_centi (temp_c),
        .o_humidity_centi    (hum_c),
        .o_crc_error         (m_axis_tuser)
    );

    assign m_axis_tdata = {3'b000, hum_c, temp_c};

endmodule

>>> hdl/htfd_checker.sv
// Port-level checker for the frame decoder, bound to the top level.
module htfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) >= -15'sd4500)
                       && ($signed(m_axis_tdata[14:0]) <= 15'sd12999))
        else $error("temperature out of range");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[28:15] <= 14'd9999) && (m_axis_tdata[31:29] == 3'd0))
        else $error("humidity out of range");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/tb.sv
// Self-checking testbench for the humidity/temperature measurement frame decoder.
module tb;

    localparam int LIMIT_CYCLES = 300000;

    typedef struct {
        logic signed [14:0] temp;
        logic [13:0]        hum;
        logic               crc_err;
    } t_reading;

    class measurement_scoreboard;
        logic [2:0]  position;
        logic [7:0]  crc;
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic        temp_bad;
        t_reading    pending_readings[$];
        int          errors;

        function new();
            position = htfd_pkg::POS_T_HI;
            crc      = htfd_pkg::CRC_INIT;
            temp_raw = '0;
            hum_raw  = '0;
            temp_bad = 1'b0;
            errors   = 0;
        endfunction

        // bitwise CRC-8, MSB first
        function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[7] ^ b[i];
                c  = {c[6:0], 1'b0} ^ (fb ? htfd_pkg::CRC_POLY : 8'h00);
            end
            return c;
        endfunction

        function logic [7:0] word_crc(logic [15:0] w);
            return crc_step(crc_step(htfd_pkg::CRC_INIT, w[15:8]), w[7:0]);
        endfunction

        function int pending();
            return pending_readings.size();
        endfunction

        function void note_byte(logic [7:0] b, logic start);
            logic [2:0]  p;
            logic [31:0] prod;
            int          t;
            t_reading    r;
            p = (start || position > htfd_pkg::POS_H_CRC) ? htfd_pkg::POS_T_HI : position;
            case (p)
                htfd_pkg::POS_T_HI: begin
                    crc      = crc_step(htfd_pkg::CRC_INIT, b);
                    temp_raw = {b, 8'h00};
                    temp_bad = 1'b0;
                    position = htfd_pkg::POS_T_LO;
                end
                htfd_pkg::POS_T_LO: begin
                    crc      = crc_step(crc, b);
                    temp_raw = {temp_raw[15:8], b};
                    position = htfd_pkg::POS_T_CRC;
                end
                htfd_pkg::POS_T_CRC: begin
                    temp_bad = (b != crc);
                    crc      = htfd_pkg::CRC_INIT;
                    position = htfd_pkg::POS_H_HI;
                end
                htfd_pkg::POS_H_HI: begin
                    crc      = crc_step(htfd_pkg::CRC_INIT, b);
                    hum_raw  = {b, 8'h00};
                    position = htfd_pkg::POS_H_LO;
                end
                htfd_pkg::POS_H_LO: begin
                    crc      = crc_step(crc, b);
                    hum_raw  = {hum_raw[15:8], b};
                    position = htfd_pkg::POS_H_CRC;
                end
                default: begin
                    r.crc_err = temp_bad | (b != crc);
                    crc       = htfd_pkg::CRC_INIT;
                    position  = htfd_pkg::POS_T_HI;
                    prod      = 32'd4375 * temp_raw;
                    t         = int'(prod >> 14) - 4500;
                    r.temp    = t[14:0];
                    prod      = 32'd625 * hum_raw;
                    r.hum     = prod[25:12];
                    pending_readings.push_back(r);
                end
            endcase
        endfunction

        function void check_reading(logic [31:0] tdata, logic tuser);
            t_reading e;
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected reading tdata=%h tuser=%b", $time, tdata, tuser);
                errors++;
                return;
            end
            e = pending_readings.pop_front();
            if (tdata[14:0] !== e.temp) begin
                $display("%0t: temperature mismatch expected %0d actual %0d", $time,
                         e.temp, $signed(tdata[14:0]));
                errors++;
            end
            if (tdata[28:15] !== e.hum) begin
                $display("%0t: humidity mismatch expected %0d actual %0d", $time,
                         e.hum, tdata[28:15]);
                errors++;
            end
            if (tuser !== e.crc_err) begin
                $display("%0t: crc_error mismatch expected %b actual %b", $time,
                         e.crc_err, tuser);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [14:0] temperature_centi, [28:15] humidity_centi
    logic        m_axis_tuser;   // [0] crc_error

    measurement_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    int cycles;

    humidity_temp_frame_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // receiver side
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_reading(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        if (bytes_sent < 260) begin
            send_idle_pct = 9;
            recv_idle_pct = 83;
        end else if (bytes_sent < 520) begin
            send_idle_pct = 83;
            recv_idle_pct = 9;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= $urandom_range(1);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b, start);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [15:0] traw, input logic [15:0] hraw,
                              input logic start, input logic bad_t, input logic bad_h);
        logic [7:0] ct;
        logic [7:0] ch;
        ct = sb.word_crc(traw) ^ (bad_t ? 8'($urandom_range(255, 1)) : 8'h00);
        ch = sb.word_crc(hraw) ^ (bad_h ? 8'($urandom_range(255, 1)) : 8'h00);
        send_byte(traw[15:8], start);
        send_byte(traw[7:0], 1'b0);
        send_byte(ct, 1'b0);
        send_byte(hraw[15:8], 1'b0);
        send_byte(hraw[7:0], 1'b0);
        send_byte(ch, 1'b0);
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(19))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic paused;
        int   n;
        sb            = new();
        cycles        = 0;
        bytes_sent    = 0;
        paused        = 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 83;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_rst_n       = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, back-to-back frame, bad CRCs, restart mid-frame
        send_frame(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
        send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_frame(16'($urandom), 16'($urandom), 1'b1, 1'b1, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_frame(16'($urandom), 16'($urandom), 1'b1, 1'b0, 1'b1);

        while (bytes_sent < 775) begin
            if (!paused && bytes_sent >= 400) begin
                paused = 1'b1;
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                while (sb.pending() != 0) @(negedge i_clk);
            end
            if ($urandom_range(99) < 85) begin
                send_frame(pick_raw(), pick_raw(),
                           (sb.position != htfd_pkg::POS_T_HI) ? 1'b1 : 1'($urandom_range(1)),
                           $urandom_range(99) < 15, $urandom_range(99) < 15);
            end else begin
                n = $urandom_range(5, 1);
                repeat (n) send_byte(8'($urandom), $urandom_range(3) == 0);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/htfd_pkg.sv
hdl/htfd_in_reg.sv
hdl/htfd_core.sv
hdl/humidity_temp_frame_decoder.sv
hdl/htfd_checker.sv
tb/tb.sv
